// ===== hw/rtl/pps_pkg.sv =====
// Shared types and constants for the periodic pattern subtract block.
// Used by the controller, the datapath and the top level.
`default_nettype none

package pps_pkg;

  // Field widths fixed by the interface
  localparam int unsigned CW   = 14;  // baseline start/stop, period count
  localparam int unsigned LW   = 9;   // pattern length register
  localparam int unsigned SMPW = 16;  // raw sample
  localparam int unsigned RESW = 22;  // residual, 4 fractional bits
  localparam int unsigned FRAC = 4;
  localparam int unsigned ACTW = 2;
  localparam int unsigned CFG_IDX_W = 2;

  // Default sizes of the stores
  localparam int unsigned MAX_PULSE_DEF   = 8192;
  localparam int unsigned MAX_PATTERN_DEF = 256;

  // Register reset values
  localparam logic [LW-1:0] LEN_RESET   = 9'd100;
  localparam logic [CW-1:0] START_RESET = 14'd0;
  localparam logic [CW-1:0] STOP_RESET  = 14'd2000;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STOP   = 2'd2;

  // Request actions
  localparam logic [ACTW-1:0] ACT_LOAD   = 2'd0;
  localparam logic [ACTW-1:0] ACT_FINISH = 2'd1;
  localparam logic [ACTW-1:0] ACT_READ   = 2'd2;

  typedef struct packed {
    logic [ACTW-1:0]        action;
    logic signed [SMPW-1:0] sample;
  } req_t;

  typedef struct packed {
    logic signed [RESW-1:0] residual;
    logic                   pattern_valid;
    logic                   last;
  } rsp_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;        // append sample to the pulse store
    logic fin_emit;    // finish result, set pattern valid flag
    logic fin_valid;
    logic rd_issue;    // read sample and pattern for the next residual
    logic rd_emit;     // produce residual, advance read pointers
    logic cnt_start;   // divide window width by length
    logic cnt_latch;
    logic end_calc;    // window end = start + count * length
    logic walk_init;
    logic walk_read;
    logic walk_write;
    logic div_read;    // fetch phase sum
    logic div_start;   // divide 16 * sum by count
    logic div_write;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic pre_ok;
    logic chk_ok;
    logic rd_avail;
    logic walk_last;
    logic ph_last;
    logic div_done;
  } sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pps_div.sv =====
// Restoring divider for unsigned operands, one quotient bit per cycle.
// Standalone arithmetic unit with no package dependence; used by pps_datapath.
`default_nettype none

module pps_div #(
  parameter int unsigned NW = 33,  // dividend and quotient width
  parameter int unsigned DW = 14   // divisor width
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] dividend_i,
  input  wire logic [DW-1:0] divisor_i,
  output logic               done_o,
  output logic [NW-1:0]      quotient_o
);

  localparam int unsigned CNTW = $clog2(NW + 1);

  logic [CNTW-1:0] cnt_q;
  logic            done_q;
  logic [DW-1:0]   rem_q;
  logic [NW-1:0]   quo_q;
  logic [DW-1:0]   dvs_q;

  logic [DW:0]     rem_sh;
  logic            ge;
  logic [DW:0]     rem_sub;

  // Shift in the next dividend bit and try the subtract
  always_comb begin
    rem_sh  = {rem_q, quo_q[NW-1]};
    ge      = rem_sh >= {1'b0, dvs_q};
    rem_sub = rem_sh - {1'b0, dvs_q};
  end

  // Iteration counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CNTW'(NW);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - CNTW'(1);
      done_q <= (cnt_q == CNTW'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  // Remainder and quotient shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? DW'(rem_sub) : DW'(rem_sh);
      quo_q <= {quo_q[NW-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// ===== hw/rtl/pps_ctrl.sv =====
// Sequencer for the periodic pattern subtract block.
// Depends on pps_pkg for command and status structs and action codes.
`default_nettype none

module pps_ctrl import pps_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [ACTW-1:0] action_i,
  input  wire sts_t            sts_i,
  output cmd_t                 cmd_o,
  output logic                 busy_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CNT  = 4'd1;  // wait for period count
  localparam logic [3:0] S_END  = 4'd2;  // compute window end
  localparam logic [3:0] S_CHK  = 4'd3;  // check window fits the pulse
  localparam logic [3:0] S_WRD  = 4'd4;  // fetch sample and phase sum
  localparam logic [3:0] S_WWR  = 4'd5;  // accumulate phase sum
  localparam logic [3:0] S_DRD  = 4'd6;  // fetch phase sum
  localparam logic [3:0] S_DST  = 4'd7;  // start per-phase divide
  localparam logic [3:0] S_DWT  = 4'd8;  // wait divide, store pattern
  localparam logic [3:0] S_ROUT = 4'd9;  // emit residual

  logic [3:0] state_q, state_d;
  logic       accept;

  assign busy_o = (state_q != S_IDLE);
  assign accept = start_i && (state_q == S_IDLE);

  // Next state and command decode
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (action_i)
            ACT_LOAD: begin
              cmd_o.load = 1'b1;
            end
            ACT_FINISH: begin
              if (sts_i.pre_ok) begin
                cmd_o.cnt_start = 1'b1;
                state_d         = S_CNT;
              end else begin
                cmd_o.fin_emit  = 1'b1;
                cmd_o.fin_valid = 1'b0;
              end
            end
            ACT_READ: begin
              if (sts_i.rd_avail) begin
                cmd_o.rd_issue = 1'b1;
                state_d        = S_ROUT;
              end
            end
            default: begin
              // drop unused action
            end
          endcase
        end
      end
      S_CNT: begin
        if (sts_i.div_done) begin
          cmd_o.cnt_latch = 1'b1;
          state_d         = S_END;
        end
      end
      S_END: begin
        cmd_o.end_calc = 1'b1;
        state_d        = S_CHK;
      end
      S_CHK: begin
        if (sts_i.chk_ok) begin
          cmd_o.walk_init = 1'b1;
          state_d         = S_WRD;
        end else begin
          cmd_o.fin_emit  = 1'b1;
          cmd_o.fin_valid = 1'b0;
          state_d         = S_IDLE;
        end
      end
      S_WRD: begin
        cmd_o.walk_read = 1'b1;
        state_d         = S_WWR;
      end
      S_WWR: begin
        cmd_o.walk_write = 1'b1;
        state_d          = sts_i.walk_last ? S_DRD : S_WRD;
      end
      S_DRD: begin
        cmd_o.div_read = 1'b1;
        state_d        = S_DST;
      end
      S_DST: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DWT;
      end
      S_DWT: begin
        if (sts_i.div_done) begin
          cmd_o.div_write = 1'b1;
          if (sts_i.ph_last) begin
            cmd_o.fin_emit  = 1'b1;
            cmd_o.fin_valid = 1'b1;
            state_d         = S_IDLE;
          end else begin
            state_d = S_DRD;
          end
        end
      end
      S_ROUT: begin
        cmd_o.rd_emit = 1'b1;
        state_d       = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pps_datapath.sv =====
// Datapath: configuration registers, pulse store, phase pattern store,
// pointers, shared divider and result register. Depends on pps_pkg, pps_div.
`default_nettype none

module pps_datapath import pps_pkg::*; #(
  parameter int unsigned MAX_PULSE   = MAX_PULSE_DEF,
  parameter int unsigned MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CW-1:0]        cfg_data_i,
  input  wire logic signed [SMPW-1:0] sample_i,
  input  wire cmd_t                 cmd_i,
  output sts_t                      sts_o,
  output logic                      done_o,
  output rsp_t                      rsp_o
);

  localparam int unsigned PW   = $clog2(MAX_PULSE);
  localparam int unsigned AW   = $clog2(MAX_PATTERN);
  localparam int unsigned SW   = SMPW + PW + 1;          // phase sum width
  localparam int unsigned NW   = SW + 3;                 // |16 * sum|
  localparam int unsigned EW   = CW + LW + 1;            // window end
  localparam int unsigned CMPW = (AW + 1 > LW) ? AW + 1 : LW;

  // Configuration
  logic [LW-1:0] len_q;
  logic [CW-1:0] start_q;
  logic [CW-1:0] stop_q;

  // Pulse and pointer state
  logic [PW:0]   loaded_q;
  logic [PW-1:0] rd_idx_q;
  logic [AW-1:0] rd_ph_q;
  logic          valid_q;
  logic [LW-1:0] blen_q;
  logic          done_q;
  rsp_t          rsp_q;

  // Pattern build state
  logic [CW-1:0] count_q;
  logic [EW-1:0] end_q;
  logic [PW-1:0] w_idx_q;
  logic [AW-1:0] w_ph_q;
  logic          first_q;

  // Stores
  logic signed [SMPW-1:0] pulse_mem_q [MAX_PULSE];
  logic signed [SW-1:0]   pat_mem_q   [MAX_PATTERN];
  logic signed [SMPW-1:0] pm_rd_q;
  logic signed [SW-1:0]   pat_rd_q;

  // Divider
  logic          div_start;
  logic [NW-1:0] div_dvd;
  logic [CW-1:0] div_dvs;
  logic          div_done;
  logic [NW-1:0] div_quo;

  logic [CW+LW-1:0]     prod_w;
  logic [CW-1:0]        diff_w;
  logic [CMPW-1:0]      len_x;
  logic [CMPW-1:0]      w_ph_nx;
  logic [CMPW-1:0]      rd_ph_nx;
  logic                 rd_wrap;
  logic                 rd_last;
  logic                 pm_we;
  logic                 pm_re;
  logic [PW-1:0]        pm_raddr;
  logic                 pat_we;
  logic                 pat_re;
  logic [AW-1:0]        pat_raddr;
  logic signed [SW-1:0] pat_wdata;
  logic signed [SW-1:0] smp_sw;
  logic signed [SW+3:0] sum16;
  logic signed [SW+3:0] mag;
  logic                 neg;
  logic signed [SW-1:0] quo_s;
  logic signed [RESW-1:0] scaled;
  logic signed [RESW-1:0] pat_ext;
  logic signed [RESW-1:0] residual;
  logic                 use_pat;

  // Status toward the controller
  always_comb begin
    len_x    = CMPW'(len_q);
    diff_w   = stop_q - start_q;
    prod_w   = count_q * len_q;
    w_ph_nx  = CMPW'(w_ph_q) + CMPW'(1);
    rd_ph_nx = CMPW'(rd_ph_q) + CMPW'(1);
    rd_wrap  = (rd_ph_nx >= len_x) || (rd_ph_nx >= CMPW'(MAX_PATTERN));
    rd_last  = ((PW+1)'(rd_idx_q) + (PW+1)'(1)) == loaded_q;

    sts_o.pre_ok    = (len_q != '0) && (len_x <= CMPW'(MAX_PATTERN)) && (stop_q >= start_q);
    sts_o.chk_ok    = (count_q != '0) && (end_q <= EW'(loaded_q));
    sts_o.rd_avail  = (PW+1)'(rd_idx_q) < loaded_q;
    sts_o.walk_last = (EW'(w_idx_q) + EW'(1)) == end_q;
    sts_o.ph_last   = (w_ph_nx == len_x);
    sts_o.div_done  = div_done;
  end

  // Divider operand select: period count or per-phase average
  always_comb begin
    sum16     = {pat_rd_q, 4'b0000};
    neg       = pat_rd_q[SW-1];
    mag       = neg ? -sum16 : sum16;
    div_start = cmd_i.cnt_start || cmd_i.div_start;
    div_dvd   = cmd_i.cnt_start ? NW'(diff_w) : NW'(mag);
    div_dvs   = cmd_i.cnt_start ? CW'(len_q) : count_q;
    quo_s     = neg ? -$signed(SW'(div_quo)) : $signed(SW'(div_quo));
  end

  pps_div #(
    .NW (NW),
    .DW (CW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Memory port control
  always_comb begin
    pm_we     = cmd_i.load && (loaded_q < (PW+1)'(MAX_PULSE));
    pm_re     = cmd_i.rd_issue || cmd_i.walk_read;
    pm_raddr  = cmd_i.rd_issue ? rd_idx_q : w_idx_q;
    pat_re    = cmd_i.rd_issue || cmd_i.walk_read || cmd_i.div_read;
    pat_raddr = cmd_i.rd_issue ? rd_ph_q : w_ph_q;
    pat_we    = cmd_i.walk_write || cmd_i.div_write;
    smp_sw    = SW'(pm_rd_q);
    if (cmd_i.div_write) begin
      pat_wdata = quo_s;
    end else if (first_q) begin
      pat_wdata = smp_sw;
    end else begin
      pat_wdata = pat_rd_q + smp_sw;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pm_we) begin
      pulse_mem_q[loaded_q[PW-1:0]] <= sample_i;
    end
    if (pm_re) begin
      pm_rd_q <= pulse_mem_q[pm_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pat_we) begin
      pat_mem_q[w_ph_q] <= pat_wdata;
    end
    if (pat_re) begin
      pat_rd_q <= pat_mem_q[pat_raddr];
    end
  end

  // Residual: 16 * sample minus pattern, pattern zero past the built length
  always_comb begin
    scaled   = RESW'(pm_rd_q) <<< FRAC;
    pat_ext  = RESW'(pat_rd_q);
    use_pat  = valid_q && (CMPW'(rd_ph_q) < CMPW'(blen_q));
    residual = use_pat ? (scaled - pat_ext) : scaled;
  end

  // Configuration, pointers, flags and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= LEN_RESET;
      start_q  <= START_RESET;
      stop_q   <= STOP_RESET;
      loaded_q <= '0;
      rd_idx_q <= '0;
      rd_ph_q  <= '0;
      valid_q  <= 1'b0;
      blen_q   <= '0;
      done_q   <= 1'b0;
    end else begin
      done_q <= cmd_i.fin_emit || cmd_i.rd_emit;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_LENGTH: len_q   <= cfg_data_i[LW-1:0];
          REG_START:  start_q <= cfg_data_i;
          REG_STOP:   stop_q  <= cfg_data_i;
          default: begin
            // drop writes to unused index
          end
        endcase
      end
      if (pm_we) begin
        loaded_q <= loaded_q + (PW+1)'(1);
      end
      if (cmd_i.fin_emit) begin
        valid_q  <= cmd_i.fin_valid;
        rd_idx_q <= '0;
        rd_ph_q  <= '0;
        if (cmd_i.fin_valid) begin
          blen_q <= len_q;
        end
      end
      if (cmd_i.rd_emit) begin
        if (rd_last) begin
          loaded_q <= '0;
          rd_idx_q <= '0;
          rd_ph_q  <= '0;
          valid_q  <= 1'b0;
        end else begin
          rd_idx_q <= rd_idx_q + PW'(1);
          rd_ph_q  <= rd_wrap ? '0 : AW'(rd_ph_nx);
        end
      end
    end
  end

  // Pattern build registers and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.cnt_latch) begin
      count_q <= CW'(div_quo);
    end
    if (cmd_i.end_calc) begin
      end_q <= EW'(start_q) + EW'(prod_w);
    end
    if (cmd_i.walk_init) begin
      w_idx_q <= PW'(start_q);
      w_ph_q  <= '0;
      first_q <= 1'b1;
    end
    if (cmd_i.walk_write) begin
      w_idx_q <= w_idx_q + PW'(1);
      if (sts_o.walk_last || sts_o.ph_last) begin
        w_ph_q <= '0;
      end else begin
        w_ph_q <= AW'(w_ph_nx);
      end
      if (sts_o.ph_last) begin
        first_q <= 1'b0;
      end
    end
    if (cmd_i.div_write) begin
      w_ph_q <= AW'(w_ph_nx);
    end
    if (cmd_i.fin_emit) begin
      rsp_q.residual      <= '0;
      rsp_q.pattern_valid <= cmd_i.fin_valid;
      rsp_q.last          <= 1'b0;
    end else if (cmd_i.rd_emit) begin
      rsp_q.residual      <= residual;
      rsp_q.pattern_valid <= valid_q;
      rsp_q.last          <= rd_last;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire

// ===== hw/rtl/periodic_pattern_subtract_core.sv =====
// Periodic pattern subtract, top level: controller plus datapath.
// Depends on pps_pkg, pps_ctrl, pps_datapath and pps_div.
//
// Requests are taken when start is high and busy is low; results appear
// for exactly one cycle with done_o high and cannot be held off, so the
// receiver must take every strobe. A load request gives no result. A read
// request gives a residual only while a loaded sample is left to read; it
// passes the registered pulse and pattern store reads, then the result register.
// A finish request first divides the window width by the length on the
// shared one-bit-per-cycle divider, then walks the baseline window sample
// by sample through the read-modify-write of the phase sum store, then
// divides each phase sum on the same divider and stores the pattern. If the
// settings or the loaded pulse allow no pattern, it gives its result with
// pattern_valid low. The pattern store needs no clearing after reset.
`default_nettype none

module periodic_pattern_subtract_core import pps_pkg::*; #(
  parameter int unsigned MAX_PULSE   = MAX_PULSE_DEF,
  parameter int unsigned MAX_PATTERN = MAX_PATTERN_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire req_t                 req_i,
  output logic                      done_o,
  output rsp_t                      rsp_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CW-1:0]        cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  pps_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .action_i (req_i.action),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  pps_datapath #(
    .MAX_PULSE   (MAX_PULSE),
    .MAX_PATTERN (MAX_PATTERN)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .sample_i   (req_i.sample),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .done_o     (done_o),
    .rsp_o      (rsp_o)
  );

endmodule

`default_nettype wire

// ===== bench/periodic_pattern_subtract_core_test.sv =====
// Self-checking bench for periodic_pattern_subtract_core: drives load, finish
// and read requests, predicts every residual in-bench and checks each strobe.
// Depends on pps_pkg and the periodic_pattern_subtract_core RTL.

module periodic_pattern_subtract_core_test;
  import pps_pkg::*;

  // Action code that the block ignores
  localparam logic [ACTW-1:0] ACT_NONE = 2'd3;

  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_ITEMS  = 1000;
  localparam int unsigned MAX_REPORTS   = 40;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  req_t                 req_i;
  logic                 done_o;
  rsp_t                 rsp_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CW-1:0]        cfg_data_i;

  periodic_pattern_subtract_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .done_o     (done_o),
    .rsp_o      (rsp_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Mirror of the block state
  logic signed [SMPW-1:0] pulse_mem [MAX_PULSE_DEF];
  int                     phase_pattern_mem [MAX_PATTERN_DEF];
  int unsigned            loaded_cnt = 0;
  int unsigned            rd_idx     = 0;
  int unsigned            rd_phase   = 0;
  bit                     pat_valid  = 1'b0;
  int unsigned            len_reg    = LEN_RESET;
  int unsigned            start_reg  = START_RESET;
  int unsigned            stop_reg   = STOP_RESET;

  rsp_t        residuals_due [$];
  int unsigned mismatches      = 0;
  int unsigned effective_items = 0;
  int unsigned burst_left      = 0;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t: %s", $time, what);
  endtask

  function automatic req_t pack_request(input logic [ACTW-1:0] act,
                                        input logic signed [SMPW-1:0] smp);
    req_t r;
    r.action = act;
    r.sample = smp;
    return r;
  endfunction

  // Favor the sample extremes, otherwise any 16-bit value
  function automatic logic signed [SMPW-1:0] rand_sample();
    case ($urandom_range(0, 11))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      3: return '1;
      default: return SMPW'($urandom);
    endcase
  endfunction

  // Average the baseline window per phase into the pattern
  function automatic void build_phase_pattern();
    longint      sums [MAX_PATTERN_DEF];
    longint      periods;
    longint      win_end;
    int unsigned ph;
    foreach (phase_pattern_mem[k]) phase_pattern_mem[k] = 0;
    pat_valid = 1'b0;
    if (len_reg < 1 || len_reg > MAX_PATTERN_DEF) return;
    if (stop_reg < start_reg) return;
    periods = (stop_reg - start_reg) / len_reg;
    if (periods < 1) return;
    win_end = start_reg + periods * len_reg;
    if (win_end > loaded_cnt) return;
    foreach (sums[k]) sums[k] = 0;
    ph = 0;
    for (longint i = start_reg; i < win_end; i++) begin
      sums[ph] += pulse_mem[i];
      ph++;
      if (ph >= len_reg) ph = 0;
    end
    for (int unsigned p = 0; p < len_reg; p++) begin
      phase_pattern_mem[p] = int'((sums[p] * 16) / periods);
    end
    pat_valid = 1'b1;
  endfunction

  // Advance the mirror by one accepted request and queue its result
  function automatic void step_pattern_subtract(input req_t r);
    rsp_t        res;
    int          acc;
    int unsigned nxt;
    bit          is_last;
    case (r.action)
      ACT_LOAD: begin
        if (loaded_cnt < MAX_PULSE_DEF) begin
          pulse_mem[loaded_cnt] = r.sample;
          loaded_cnt++;
          effective_items++;
        end
      end
      ACT_FINISH: begin
        build_phase_pattern();
        rd_idx            = 0;
        rd_phase          = 0;
        res               = '0;
        res.pattern_valid = pat_valid;
        residuals_due.push_back(res);
        effective_items++;
      end
      ACT_READ: begin
        if (rd_idx < loaded_cnt && rd_idx < MAX_PULSE_DEF) begin
          acc = pulse_mem[rd_idx] * 16;
          if (pat_valid && rd_phase < MAX_PATTERN_DEF) acc = acc - phase_pattern_mem[rd_phase];
          is_last           = (rd_idx + 1 == loaded_cnt);
          res.residual      = acc[RESW-1:0];
          res.pattern_valid = pat_valid;
          res.last          = is_last;
          residuals_due.push_back(res);
          effective_items++;
          nxt = rd_phase + 1;
          if (nxt >= len_reg || nxt >= MAX_PATTERN_DEF) nxt = 0;
          rd_phase = nxt;
          rd_idx++;
          // End of pulse: ready for a new one
          if (is_last) begin
            loaded_cnt = 0;
            rd_idx     = 0;
            rd_phase   = 0;
            pat_valid  = 1'b0;
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Present one request, at random idling first when the current burst is used up
  task automatic send_req(input req_t r);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
    end
    burst_left--;
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy !== 1'b0);
    step_pattern_subtract(r);
  endtask

  // Hold off until every predicted result has arrived and the block settles
  task automatic drain();
    start <= 1'b0;
    burst_left = 0;
    while (residuals_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
  endtask

  task automatic set_config(input int unsigned len, first, stop);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_LENGTH;
    cfg_data_i <= len[CW-1:0];
    @(posedge clk_i);
    len_reg    = len[LW-1:0];
    cfg_idx_i  <= REG_START;
    cfg_data_i <= first[CW-1:0];
    @(posedge clk_i);
    start_reg  = first[CW-1:0];
    cfg_idx_i  <= REG_STOP;
    cfg_data_i <= stop[CW-1:0];
    @(posedge clk_i);
    stop_reg   = stop[CW-1:0];
    cfg_we_i   <= 1'b0;
  endtask

  // Read until the pulse ends; noisy mode mixes in appends, rebuilds and idles
  task automatic read_out(input bit noisy);
    int unsigned pick;
    while (loaded_cnt != 0) begin
      pick = noisy ? $urandom_range(0, 59) : 59;
      if (pick == 0) send_req(pack_request(ACT_LOAD, rand_sample()));
      else if (pick == 1) send_req(pack_request(ACT_NONE, rand_sample()));
      else if (pick == 2) send_req(pack_request(ACT_FINISH, rand_sample()));
      else if (pick == 3) drain();
      else send_req(pack_request(ACT_READ, rand_sample()));
    end
  endtask

  task automatic run_pulse(input int unsigned n, input bit noisy);
    repeat (n) send_req(pack_request(ACT_LOAD, rand_sample()));
    if (noisy && $urandom_range(0, 9) == 0) send_req(pack_request(ACT_NONE, rand_sample()));
    send_req(pack_request(ACT_FINISH, rand_sample()));
    read_out(noisy);
    // Read with nothing left
    if (noisy && $urandom_range(0, 3) == 0) send_req(pack_request(ACT_READ, rand_sample()));
  endtask

  // Reset registers: window far beyond a short pulse, so samples pass through
  task automatic test_reset_config();
    send_req(pack_request(ACT_READ, 16'sh1234));
    send_req(pack_request(ACT_LOAD, 16'sh8000));
    send_req(pack_request(ACT_LOAD, 16'sh7fff));
    send_req(pack_request(ACT_LOAD, 16'sh0000));
    send_req(pack_request(ACT_LOAD, 16'shffff));
    send_req(pack_request(ACT_NONE, 16'sh5555));
    send_req(pack_request(ACT_FINISH, 16'shaaaa));
    read_out(1'b0);
    send_req(pack_request(ACT_READ, 16'sh0000));
  endtask

  // Three periods of two: pattern with truncation, append during readout
  task automatic test_short_pattern();
    set_config(2, 1, 7);
    send_req(pack_request(ACT_LOAD, 16'sd100));
    send_req(pack_request(ACT_LOAD, -16'sd7));
    send_req(pack_request(ACT_LOAD, 16'sh7fff));
    send_req(pack_request(ACT_LOAD, 16'sh8000));
    send_req(pack_request(ACT_LOAD, 16'sd3));
    send_req(pack_request(ACT_LOAD, 16'sd4));
    send_req(pack_request(ACT_LOAD, 16'sh7fff));
    send_req(pack_request(ACT_LOAD, -16'sd1));
    send_req(pack_request(ACT_FINISH, '0));
    repeat (3) send_req(pack_request(ACT_READ, '0));
    send_req(pack_request(ACT_LOAD, 16'sh8000));
    read_out(1'b0);
  endtask

  // Settings where no pattern can be built
  task automatic test_no_pattern();
    set_config(0, 0, 10);       // zero length
    run_pulse(2, 1'b0);
    set_config(300, 0, 600);    // length above the pattern store
    run_pulse(2, 1'b0);
    set_config(4, 9, 3);        // stop below start
    run_pulse(2, 1'b0);
    set_config(8, 0, 7);        // window shorter than one period
    run_pulse(2, 1'b0);
    set_config(1, 8192, 8192);  // window at the top of the range
    run_pulse(2, 1'b0);
  endtask

  task automatic test_random_pulses();
    int unsigned base;
    int unsigned len, first, stop, win_end, n;
    base = effective_items;
    while (effective_items - base < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin
          len   = $urandom_range(1, 12);
          first = $urandom_range(0, 10);
          stop  = first + len * $urandom_range(1, 4) + $urandom_range(0, len - 1);
        end
        7: begin
          len   = $urandom_range(13, 40);
          first = $urandom_range(0, 20);
          stop  = first + len * $urandom_range(1, 2) + $urandom_range(0, len - 1);
        end
        8: begin
          len   = $urandom_range(1, 3);
          first = 0;
          stop  = $urandom_range(1, 40);
        end
        default: begin
          // Drop into a setting that cannot build a pattern
          case ($urandom_range(0, 3))
            0: begin
              len   = 0;
              first = $urandom_range(0, 5);
              stop  = first + $urandom_range(1, 30);
            end
            1: begin
              len   = $urandom_range(257, 511);
              first = $urandom_range(0, 5);
              stop  = first + $urandom_range(257, 600);
            end
            2: begin
              len   = $urandom_range(1, 12);
              first = $urandom_range(1, 30);
              stop  = $urandom_range(0, first - 1);
            end
            default: begin
              len   = $urandom_range(2, 12);
              first = $urandom_range(0, 10);
              stop  = first + $urandom_range(0, len - 1);
            end
          endcase
        end
      endcase
      set_config(len, first, stop);
      if (len >= 1 && len <= MAX_PATTERN_DEF && stop >= first && (stop - first) / len >= 1) begin
        win_end = first + ((stop - first) / len) * len;
      end else begin
        win_end = 0;
      end
      repeat ($urandom_range(2, 5)) begin
        if (win_end != 0 && $urandom_range(0, 4) != 0) n = win_end + $urandom_range(0, 8);
        else n = $urandom_range(1, win_end + 12);
        run_pulse(n, 1'b1);
      end
    end
  endtask

  // Full-size period: phase wraps at the end of the pattern store
  task automatic test_long_period();
    set_config(MAX_PATTERN_DEF, 0, 2 * MAX_PATTERN_DEF - 1);
    run_pulse(MAX_PATTERN_DEF + 44, 1'b0);
  endtask

  // Compare each result strobe with the oldest predicted result
  always @(posedge clk_i) begin : check_results
    rsp_t want;
    if (rst_ni === 1'b1 && done_o !== 1'b0) begin
      if (residuals_due.size() == 0) begin
        report_mismatch($sformatf("result with none pending: %h", rsp_o));
      end else begin
        want = residuals_due.pop_front();
        if (rsp_o.residual !== want.residual) begin
          report_mismatch($sformatf("residual %0d, want %0d", rsp_o.residual, want.residual));
        end
        if (rsp_o.pattern_valid !== want.pattern_valid) begin
          report_mismatch($sformatf("pattern_valid %b, want %b",
                                    rsp_o.pattern_valid, want.pattern_valid));
        end
        if (rsp_o.last !== want.last) begin
          report_mismatch($sformatf("last %b, want %b", rsp_o.last, want.last));
        end
      end
    end
  end

  // Run limit
  initial begin
    #40_000_000;
    $display("periodic_pattern_subtract_core: mismatch");
    $finish;
  end

  initial begin
    start      <= 1'b0;
    req_i      <= '0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= REG_LENGTH;
    cfg_data_i <= '0;
    rst_ni     <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_config();
    test_short_pattern();
    test_no_pattern();
    test_random_pulses();
    test_long_period();
    drain();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("periodic_pattern_subtract_core: match");
    end else begin
      $display("periodic_pattern_subtract_core: mismatch");
    end
    $finish;
  end

endmodule
